/* rtl/met_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// met_pkg
// Shared types and register indexes of the escape-time pixel engine.
// ----------------------------------------------------------------------------
package met_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_X_START   = 3'd0;
   localparam logic [2:0] CSR_Y_START   = 3'd1;
   localparam logic [2:0] CSR_X_STEP    = 3'd2;
   localparam logic [2:0] CSR_Y_STEP    = 3'd3;
   localparam logic [2:0] CSR_ITER_LIM  = 3'd4;
   localparam logic [2:0] CSR_POWER     = 3'd5;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP,
      ST_REG1,
      ST_REG2,
      ST_REG3,
      ST_MUL,
      ST_ADD,
      ST_MAG,
      ST_TEST,
      ST_DONE
   } state_type;

endpackage

/* rtl/met_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// met_cell
// One complex multiply stage: w_out = w_in * z_in, floor-shifted and
// saturated, with z handed on to the next cell.
// ----------------------------------------------------------------------------
module met_cell import met_pkg::*; #(
   parameter int FRAC_BITS = 28
) (
   input  logic                        clock,
   input  logic signed [FRAC_BITS+7:0] w_re_in,
   input  logic signed [FRAC_BITS+7:0] w_im_in,
   input  logic signed [FRAC_BITS+7:0] z_re_in,
   input  logic signed [FRAC_BITS+7:0] z_im_in,
   output logic signed [FRAC_BITS+7:0] w_re_out,
   output logic signed [FRAC_BITS+7:0] w_im_out,
   output logic signed [FRAC_BITS+7:0] z_re_out,
   output logic signed [FRAC_BITS+7:0] z_im_out
);
   localparam int ZW = FRAC_BITS + 8;
   localparam int PW = 2 * ZW + 1;

   logic signed [2*ZW-1:0] p_rr, p_ii, p_ri, p_ir;
   logic signed [PW-1:0]   re_full, im_full, re_sh, im_sh;
   logic signed [ZW-1:0]   w_re_ff, w_im_ff, z_re_ff, z_im_ff;

   function automatic logic signed [ZW-1:0] sat_z(input logic signed [PW-1:0] v);
      logic [PW-ZW:0] top;
      top = v[PW-1:ZW-1];
      if (&top || ~|top) begin
         return v[ZW-1:0];
      end else if (v[PW-1]) begin
         return {1'b1, {(ZW-1){1'b0}}};
      end else begin
         return {1'b0, {(ZW-1){1'b1}}};
      end
   endfunction

   // exact cross products, then floor shift and saturation
   always_comb begin
      p_rr    = w_re_in * z_re_in;
      p_ii    = w_im_in * z_im_in;
      p_ri    = w_re_in * z_im_in;
      p_ir    = w_im_in * z_re_in;
      re_full = {p_rr[2*ZW-1], p_rr} - {p_ii[2*ZW-1], p_ii};
      im_full = {p_ri[2*ZW-1], p_ri} + {p_ir[2*ZW-1], p_ir};
      re_sh   = re_full >>> FRAC_BITS;
      im_sh   = im_full >>> FRAC_BITS;
   end

   // hand result and multiplicand to the neighbour
   always_ff @(posedge clock) begin
      w_re_ff <= sat_z(re_sh);
      w_im_ff <= sat_z(im_sh);
      z_re_ff <= z_re_in;
      z_im_ff <= z_im_in;
   end

   assign w_re_out = w_re_ff;
   assign w_im_out = w_im_ff;
   assign z_re_out = z_re_ff;
   assign z_im_out = z_im_ff;

endmodule

/* rtl/mandelbrot_escape_time_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top
// Escape-time evaluation of one pixel for z -> z^power + c.
// ----------------------------------------------------------------------------
// Usage: configure the window and limits through the csr_ write port while
// busy is low. A request is taken when start is high and busy is low; the
// pixel is mapped to c = start + pixel * step in fixed point in the MAP state.
// For power 2 a cardioid and period-2 bulb test runs next (REG1 to REG3) and
// answers points inside at once with zero iterations.
// Each iteration passes z through a row of power-1 complex multiply cells,
// one cell per cycle, then adds c, squares and tests the magnitude.
// One pixel is worked on at a time.
// The result appears on the rsp_ ports for one cycle marked by rsp_valid;
// the receiver cannot stall it. Busy drops the cycle after.
// Reset returns the sequencer to idle and loads the default window,
// iteration limit 256 and power 2.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_top import met_pkg::*; #(
   parameter int PIXEL_BITS = 12,
   parameter int FRAC_BITS  = 28,
   parameter int MAX_POWER  = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [2:0]                  csr_index,
   input  logic [31:0]                 csr_wdata,
   input  logic                        start,
   output logic                        busy,
   input  logic [PIXEL_BITS-1:0]       req_pixel_x,
   input  logic [PIXEL_BITS-1:0]       req_pixel_y,
   output logic                        rsp_valid,
   output logic [15:0]                 rsp_iterations,
   output logic                        rsp_escaped,
   output logic signed [FRAC_BITS+7:0] rsp_final_real,
   output logic signed [FRAC_BITS+7:0] rsp_final_imag
);
   localparam int CW  = FRAC_BITS + 4;
   localparam int ZW  = FRAC_BITS + 8;
   localparam int NC  = MAX_POWER - 1;
   localparam int PCW = $clog2(MAX_POWER + 1);
   localparam int MW  = PIXEL_BITS + 33;
   localparam int SW  = MW + 1;
   localparam int AW  = CW + 1;
   localparam int SSW = 2 * CW + 3;
   localparam int QW  = SSW - FRAC_BITS;
   localparam int RW  = 2 * QW + 1;
   localparam int MGW = 2 * ZW + 1;
   localparam logic signed [AW-1:0]  QUARTER   = AW'(1) << (FRAC_BITS - 2);
   localparam logic signed [AW-1:0]  ONE       = AW'(1) << FRAC_BITS;
   localparam logic signed [SSW-1:0] BULB_LIM  = SSW'(1) << (2 * FRAC_BITS - 4);
   localparam logic signed [MGW-1:0] ESC_BOUND = MGW'(1) << (2 * FRAC_BITS + 4);

   // configuration registers
   logic signed [31:0] x_start_ff, y_start_ff, x_step_ff, y_step_ff;
   logic [15:0]        iter_lim_ff;
   logic [3:0]         power_ff;

   // sequencer and datapath registers
   state_type             state_ff, state_in;
   logic [PIXEL_BITS-1:0] px_ff, py_ff;
   logic [PCW-1:0]        pow_ff, pow_in, cnt_ff;
   logic [15:0]           lim_ff, it_ff;
   logic                  esc_ff;
   logic signed [CW-1:0]  cx_ff, cy_ff;
   logic signed [AW-1:0]  a_ff;
   logic signed [2*AW-1:0] aa_ff, bb_ff;
   logic signed [2*CW-1:0] y2_ff;
   logic signed [QW-1:0]  q_ff;
   logic signed [QW:0]    qa_ff;
   logic                  bulb_ff;
   logic signed [ZW-1:0]  zr_ff, zi_ff;
   logic signed [2*ZW-1:0] mr_ff, mi_ff;

   // combinational datapath
   logic signed [MW-1:0]  prod_x, prod_y;
   logic signed [SW-1:0]  sum_x, sum_y;
   logic signed [AW-1:0]  a_c, b_c;
   logic signed [SSW-1:0] s_c, bs_c;
   logic signed [QW-1:0]  q_c;
   logic signed [RW-1:0]  pq_c;
   logic                  inside_c;
   logic signed [ZW:0]    nr_c, ni_c;
   logic signed [MGW-1:0] mag_c;
   logic                  esc_c;
   logic signed [ZW-1:0]  sel_re, sel_im;

   // cell row
   logic signed [ZW-1:0] w_re[NC];
   logic signed [ZW-1:0] w_im[NC];
   logic signed [ZW-1:0] zp_re[NC];
   logic signed [ZW-1:0] zp_im[NC];

   function automatic logic signed [CW-1:0] sat_c(input logic signed [SW-1:0] v);
      logic [SW-CW:0] top;
      top = v[SW-1:CW-1];
      if (&top || ~|top) begin
         return v[CW-1:0];
      end else if (v[SW-1]) begin
         return {1'b1, {(CW-1){1'b0}}};
      end else begin
         return {1'b0, {(CW-1){1'b1}}};
      end
   endfunction

   function automatic logic signed [ZW-1:0] sat_n(input logic signed [ZW:0] v);
      if (v[ZW] == v[ZW-1]) begin
         return v[ZW-1:0];
      end else if (v[ZW]) begin
         return {1'b1, {(ZW-1){1'b0}}};
      end else begin
         return {1'b0, {(ZW-1){1'b1}}};
      end
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         x_start_ff  <= -32'sd536870912;
         y_start_ff  <= -32'sd402653184;
         x_step_ff   <= 32'sd786432;
         y_step_ff   <= 32'sd786432;
         iter_lim_ff <= 16'd256;
         power_ff    <= 4'd2;
      end else if (csr_we) begin
         case (csr_index)
            CSR_X_START:  x_start_ff  <= csr_wdata;
            CSR_Y_START:  y_start_ff  <= csr_wdata;
            CSR_X_STEP:   x_step_ff   <= csr_wdata;
            CSR_Y_STEP:   y_step_ff   <= csr_wdata;
            CSR_ITER_LIM: iter_lim_ff <= csr_wdata[15:0];
            CSR_POWER:    power_ff    <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // power clamped into the supported range
   always_comb begin
      if (power_ff < 4'd2) begin
         pow_in = PCW'(2);
      end else if (int'(power_ff) > MAX_POWER) begin
         pow_in = PCW'(MAX_POWER);
      end else begin
         pow_in = PCW'(power_ff);
      end
   end

   // row of complex multiply cells
   genvar k;
   generate
      for (k = 0; k < NC; k++) begin : g_cell
         if (k == 0) begin : g_first
            met_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
               .clock    (clock),
               .w_re_in  (zr_ff),
               .w_im_in  (zi_ff),
               .z_re_in  (zr_ff),
               .z_im_in  (zi_ff),
               .w_re_out (w_re[k]),
               .w_im_out (w_im[k]),
               .z_re_out (zp_re[k]),
               .z_im_out (zp_im[k])
            );
         end else begin : g_next
            met_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
               .clock    (clock),
               .w_re_in  (w_re[k-1]),
               .w_im_in  (w_im[k-1]),
               .z_re_in  (zp_re[k-1]),
               .z_im_in  (zp_im[k-1]),
               .w_re_out (w_re[k]),
               .w_im_out (w_im[k]),
               .z_re_out (zp_re[k]),
               .z_im_out (zp_im[k])
            );
         end
      end
   endgenerate

   // tap of the cell that holds z^power
   always_comb begin
      sel_re = w_re[0];
      sel_im = w_im[0];
      for (int i = 0; i < NC; i++) begin
         if (i + 2 == int'(pow_ff)) begin
            sel_re = w_re[i];
            sel_im = w_im[i];
         end
      end
   end

   // pixel mapping, region tests, add and magnitude
   always_comb begin
      prod_x   = $signed({1'b0, px_ff}) * x_step_ff;
      prod_y   = $signed({1'b0, py_ff}) * y_step_ff;
      sum_x    = SW'(x_start_ff) + SW'(prod_x);
      sum_y    = SW'(y_start_ff) + SW'(prod_y);
      a_c      = AW'(cx_ff) - QUARTER;
      b_c      = AW'(cx_ff) + ONE;
      s_c      = SSW'(aa_ff) + SSW'(y2_ff);
      bs_c     = SSW'(bb_ff) + SSW'(y2_ff);
      q_c      = QW'(s_c >>> FRAC_BITS);
      pq_c     = q_ff * qa_ff;
      inside_c = bulb_ff || (pq_c <= RW'(y2_ff >>> 2));
      nr_c     = (ZW+1)'(sel_re) + (ZW+1)'(cx_ff);
      ni_c     = (ZW+1)'(sel_im) + (ZW+1)'(cy_ff);
      mag_c    = MGW'(mr_ff) + MGW'(mi_ff);
      esc_c    = mag_c > ESC_BOUND;
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_MAP;
         end
         ST_MAP: begin
            if (pow_ff == PCW'(2)) state_in = ST_REG1;
            else if (lim_ff == 16'd0) state_in = ST_DONE;
            else state_in = ST_MUL;
         end
         ST_REG1: state_in = ST_REG2;
         ST_REG2: state_in = ST_REG3;
         ST_REG3: begin
            if (inside_c || lim_ff == 16'd0) state_in = ST_DONE;
            else state_in = ST_MUL;
         end
         ST_MUL: begin
            if (cnt_ff == pow_ff - PCW'(1)) state_in = ST_ADD;
         end
         ST_ADD: state_in = ST_MAG;
         ST_MAG: state_in = ST_TEST;
         ST_TEST: begin
            if (esc_c || it_ff + 16'd1 == lim_ff) state_in = ST_DONE;
            else state_in = ST_MUL;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               px_ff  <= req_pixel_x;
               py_ff  <= req_pixel_y;
               pow_ff <= pow_in;
               lim_ff <= iter_lim_ff;
               it_ff  <= 16'd0;
               esc_ff <= 1'b0;
               zr_ff  <= '0;
               zi_ff  <= '0;
            end
         end
         ST_MAP: begin
            cx_ff  <= sat_c(sum_x);
            cy_ff  <= sat_c(sum_y);
            cnt_ff <= PCW'(1);
         end
         ST_REG1: begin
            a_ff  <= a_c;
            aa_ff <= a_c * a_c;
            bb_ff <= b_c * b_c;
            y2_ff <= cy_ff * cy_ff;
         end
         ST_REG2: begin
            q_ff    <= q_c;
            qa_ff   <= (QW+1)'(q_c) + (QW+1)'(a_ff);
            bulb_ff <= bs_c <= BULB_LIM;
         end
         ST_MUL: begin
            cnt_ff <= cnt_ff + PCW'(1);
         end
         ST_ADD: begin
            zr_ff <= sat_n(nr_c);
            zi_ff <= sat_n(ni_c);
         end
         ST_MAG: begin
            mr_ff <= zr_ff * zr_ff;
            mi_ff <= zi_ff * zi_ff;
         end
         ST_TEST: begin
            cnt_ff <= PCW'(1);
            if (esc_c) esc_ff <= 1'b1;
            else it_ff <= it_ff + 16'd1;
         end
         default: ;
      endcase
   end

   // result ports
   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_DONE);
   assign rsp_iterations = it_ff;
   assign rsp_escaped    = esc_ff;
   assign rsp_final_real = zr_ff;
   assign rsp_final_imag = zi_ff;

   // checks
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after result");
   a_take: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("request not taken");
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_escaped |-> it_ff == 16'd0 || it_ff == lim_ff)
      else $error("bad iteration count");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> cnt_ff < pow_ff) else $error("cell tap overrun");

endmodule
